/* sv/wfps_pkg.sv */
// shared types and constants for the wall-follow steering block
`default_nettype none

package wfps_pkg;

  // field widths
  localparam int RANGE_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 8;
  localparam int LIN_W    = 10;
  localparam int TURN_W   = 14;
  localparam int ERR_W    = 17;
  localparam int INTEG_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // default number of fraction bits of distances and speeds
  localparam int DIST_FRAC_BITS_DEF = 12;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOLLOW_LEFT = 3'd0,
    CFG_HALT        = 3'd1,
    CFG_TARGET      = 3'd2,
    CFG_KP          = 3'd3,
    CFG_KI_DT       = 3'd4,
    CFG_KD_OVER_DT  = 3'd5,
    CFG_LOST_LIMIT  = 3'd6
  } wfps_cfg_idx_e;

  // controller gains, signed q8.8
  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki_dt;
    logic signed [GAIN_W-1:0] kd_over_dt;
  } wfps_gains_t;

  // steering mode for the current tick
  typedef struct packed {
    logic obstacle;  // front closer than target
    logic lost;      // lost flag after this tick's update
  } wfps_mode_t;

endpackage

`default_nettype wire

/* sv/wfps_lost_det.sv */
// obstacle and lost-wall detector with its tick counter and lost flag
`default_nettype none

module wfps_lost_det
  import wfps_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire logic                halt_i,
  input  wire logic                follow_left_i,
  input  wire logic [RANGE_W-1:0]  target_i,
  input  wire logic [LIMIT_W-1:0]  lost_limit_i,
  input  wire logic [RANGE_W-1:0]  front_i,
  input  wire logic [RANGE_W-1:0]  left_i,
  input  wire logic [RANGE_W-1:0]  right_i,
  output wfps_mode_t               mode_o
);

  logic [LIMIT_W-1:0] ticks_q, ticks_d, ticks_inc;
  logic               lost_q, lost_d;
  logic [RANGE_W-1:0] side;
  logic               all_far, near_wall, front_near;

  // range comparisons against the target
  assign side       = follow_left_i ? left_i : right_i;
  assign front_near = front_i < target_i;
  assign all_far    = (front_i > target_i) && (left_i > target_i) && (right_i > target_i);
  assign near_wall  = front_near || (side < target_i);
  assign ticks_inc  = (ticks_q < lost_limit_i) ? ticks_q + 1'b1 : ticks_q;

  // lost rules
  always_comb begin
    ticks_d = ticks_q;
    lost_d  = lost_q;
    if (all_far) begin
      ticks_d = ticks_inc;
      if (ticks_inc >= lost_limit_i) begin
        lost_d = 1'b1;
      end
    end else if (near_wall) begin
      ticks_d = '0;
      lost_d  = 1'b0;
    end
  end

  // state only moves on a live tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= '0;
      lost_q  <= 1'b0;
    end else if (fire_i && !halt_i) begin
      ticks_q <= ticks_d;
      lost_q  <= lost_d;
    end
  end

  assign mode_o.obstacle = front_near;
  assign mode_o.lost     = halt_i ? lost_q : lost_d;

endmodule

`default_nettype wire

/* sv/wfps_pid.sv */
// pid turn-rate datapath with error history, saturating integral and clamps
`default_nettype none

module wfps_pid
  import wfps_pkg::*;
#(
  parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     update_i,
  input  wire logic                     follow_left_i,
  input  wire logic [RANGE_W-1:0]       target_i,
  input  wire logic [RANGE_W-1:0]       side_i,
  input  wire wfps_gains_t              gains_i,
  output logic signed [TURN_W-1:0]      turn_o
);

  localparam int ACC_W  = 50;
  localparam int SH_W   = ACC_W - 8;
  localparam int TV_W   = SH_W + 1;
  localparam int OneQ      = 1 << DIST_FRAC_BITS;
  localparam int ClampSoft = (4 * OneQ + 5) / 10;
  localparam int TurnMax   = (5 * OneQ) / 4;
  localparam logic signed [TV_W-1:0] SOFT_HI = TV_W'(ClampSoft);
  localparam logic signed [TV_W-1:0] SOFT_LO = -TV_W'(ClampSoft);
  localparam logic signed [TV_W-1:0] HARD_HI = TV_W'(TurnMax);
  localparam logic signed [TV_W-1:0] HARD_LO = -TV_W'(TurnMax);

  logic signed [ERR_W-1:0]   prev_err_q;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W:0]     der;
  logic signed [INTEG_W:0]   integ_wide;
  logic signed [32:0]        p_kp;
  logic signed [47:0]        p_ki;
  logic signed [33:0]        p_kd;
  logic signed [ACC_W-1:0]   acc;
  logic signed [SH_W-1:0]    sh;
  logic signed [TV_W-1:0]    tv, t_soft, t_hard;

  // error, derivative and saturating integral
  assign err        = $signed({1'b0, target_i}) - $signed({1'b0, side_i});
  assign der        = $signed({err[ERR_W-1], err}) - $signed({prev_err_q[ERR_W-1], prev_err_q});
  assign integ_wide = $signed({integ_q[INTEG_W-1], integ_q})
                    + $signed({{(INTEG_W-ERR_W+1){err[ERR_W-1]}}, err});

  always_comb begin
    if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1]) begin
      integ_d = integ_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                    : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_d = integ_wide[INTEG_W-1:0];
    end
  end

  // three products and exact sum
  assign p_kp = gains_i.kp * err;
  assign p_ki = gains_i.ki_dt * integ_d;
  assign p_kd = gains_i.kd_over_dt * der;
  assign acc  = $signed({{(ACC_W-33){p_kp[32]}}, p_kp})
              + $signed({{(ACC_W-48){p_ki[47]}}, p_ki})
              + $signed({{(ACC_W-34){p_kd[33]}}, p_kd});

  // arithmetic shift gives floor division by 256
  assign sh = acc[ACC_W-1:8];
  assign tv = follow_left_i ? -$signed({sh[SH_W-1], sh}) : $signed({sh[SH_W-1], sh});

  // soft clamp, one-sided for left following, then hard saturation
  always_comb begin
    t_soft = tv;
    if (tv > SOFT_HI) begin
      t_soft = SOFT_HI;
    end else if (!follow_left_i && (tv < SOFT_LO)) begin
      t_soft = SOFT_LO;
    end
    t_hard = t_soft;
    if (t_soft > HARD_HI) begin
      t_hard = HARD_HI;
    end else if (t_soft < HARD_LO) begin
      t_hard = HARD_LO;
    end
  end

  assign turn_o = t_hard[TURN_W-1:0];

  // error history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integ_q    <= '0;
    end else if (update_i) begin
      prev_err_q <= err;
      integ_q    <= integ_d;
    end
  end

endmodule

`default_nettype wire

/* sv/wall_follow_pid_steering_top.sv */
// top level of the wall-follow pid steering controller
`default_nettype none

// Wall-following steering controller. Each input beat carries the front, left
// and right ranges and yields exactly one output beat with linear speed and
// turn rate in the distance fixed-point format, plus the lost flag. An item goes
// through an input register and one pass of logic into the output register; a
// new beat is taken every cycle and throughput is one beat per cycle while
// m_axis_tready does not stall the output. The three gain multipliers sit in
// that pass alongside the error and integral update. The user must write
// configuration through a plain write port only while no beat is in flight; the
// block does not enforce this. Halt zeroes the speeds and freezes all controller state.

module wall_follow_pid_steering_top
  import wfps_pkg::*;
#(
  parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [47:0]            s_axis_tdata,  // front_range, left_range, right_range
  // output stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [31:0]                 m_axis_tdata   // linear_speed, turn_rate, lost, zero pad
);

  localparam int OneQ      = 1 << DIST_FRAC_BITS;
  localparam int TurnMax   = (5 * OneQ) / 4;
  localparam int FwdSpeed  = (8 * OneQ + 50) / 100;
  localparam int BackSpeed = (4 * OneQ + 50) / 100;
  localparam logic signed [TURN_W-1:0] TURN_POS = TURN_W'(TurnMax);
  localparam logic signed [TURN_W-1:0] TURN_NEG = TURN_W'(-TurnMax);
  localparam logic signed [LIN_W-1:0]  LIN_FWD  = LIN_W'(FwdSpeed);
  localparam logic signed [LIN_W-1:0]  LIN_BACK = LIN_W'(-BackSpeed);

  // configuration registers
  logic               follow_left_q, halt_q;
  logic [RANGE_W-1:0] target_q;
  wfps_gains_t        gains_q;
  logic [LIMIT_W-1:0] lost_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follow_left_q    <= 1'b0;
      halt_q           <= 1'b0;
      target_q         <= RANGE_W'(2048);
      gains_q.kp       <= GAIN_W'(256);
      gains_q.ki_dt    <= '0;
      gains_q.kd_over_dt <= '0;
      lost_limit_q     <= LIMIT_W'(100);
    end else if (cfg_we_i) begin
      case (wfps_cfg_idx_e'(cfg_index_i))
        CFG_FOLLOW_LEFT: follow_left_q      <= cfg_data_i[0];
        CFG_HALT:        halt_q             <= cfg_data_i[0];
        CFG_TARGET:      target_q           <= cfg_data_i;
        CFG_KP:          gains_q.kp         <= cfg_data_i;
        CFG_KI_DT:       gains_q.ki_dt      <= cfg_data_i;
        CFG_KD_OVER_DT:  gains_q.kd_over_dt <= cfg_data_i;
        CFG_LOST_LIMIT:  lost_limit_q       <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline advance
  logic in_valid_q, out_valid_q, advance, fire, s_accept;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // input register
  logic [RANGE_W-1:0] front_q, left_q, right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      front_q <= s_axis_tdata[15:0];
      left_q  <= s_axis_tdata[31:16];
      right_q <= s_axis_tdata[47:32];
    end
  end

  // mode detection
  wfps_mode_t mode;

  wfps_lost_det u_lost_det (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .halt_i        (halt_q),
    .follow_left_i (follow_left_q),
    .target_i      (target_q),
    .lost_limit_i  (lost_limit_q),
    .front_i       (front_q),
    .left_i        (left_q),
    .right_i       (right_q),
    .mode_o        (mode)
  );

  // pid steering
  logic                     pid_update;
  logic signed [TURN_W-1:0] pid_turn;

  assign pid_update = fire && !halt_q && !mode.obstacle && !mode.lost;

  wfps_pid #(
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_pid (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .update_i      (pid_update),
    .follow_left_i (follow_left_q),
    .target_i      (target_q),
    .side_i        (follow_left_q ? left_q : right_q),
    .gains_i       (gains_q),
    .turn_o        (pid_turn)
  );

  // result selection
  logic signed [LIN_W-1:0]  lin_d, lin_q;
  logic signed [TURN_W-1:0] turn_d, turn_q;
  logic                     lost_q;

  always_comb begin
    if (halt_q) begin
      lin_d  = '0;
      turn_d = '0;
    end else if (mode.obstacle) begin
      lin_d  = LIN_BACK;
      turn_d = follow_left_q ? TURN_NEG : TURN_POS;
    end else if (mode.lost) begin
      lin_d  = LIN_FWD;
      turn_d = '0;
    end else begin
      lin_d  = LIN_FWD;
      turn_d = pid_turn;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      lin_q  <= lin_d;
      turn_q <= turn_d;
      lost_q <= mode.lost;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, lost_q, turn_q, lin_q};

endmodule

`default_nettype wire
